// ===== sv/rmf_pkg.sv =====
package rmf_pkg;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int SZ_W           = 11;   // size register / counter width
   localparam int CH_W           = 8;
   localparam int PIX_W          = 24;
   localparam int WIN_N          = 9;
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);

   localparam logic [0:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [WIN_N-1:0][CH_W-1:0]  chan_win_type;
   typedef logic [WIN_N-1:0][PIX_W-1:0] pix_win_type;
endpackage

// ===== sv/rmf_ram.sv =====
module rmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/rmf_lane.sv =====
// One color channel: ranks every window element, flags the one at rank n/2.
module rmf_lane
   import rmf_pkg::*;
(
   input  logic                  clock,
   input  chan_win_type          vals,
   input  logic [WIN_N-1:0]      mask,
   output chan_win_type          vals_out,
   output logic [WIN_N-1:0]      sel_out
);
   chan_win_type     vals_ff;
   logic [WIN_N-1:0] sel_ff;
   logic [WIN_N-1:0] sel_in;
   logic [3:0]       n_cnt;
   logic [3:0]       rank [WIN_N];

   always_comb begin
      n_cnt = 4'($countones(mask));
      for (int i = 0; i < WIN_N; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WIN_N; j++) begin
            if (mask[j] && ((vals[j] < vals[i]) || (vals[j] == vals[i] && j < i))) begin
               rank[i] = rank[i] + 4'd1;
            end
         end
         sel_in[i] = mask[i] && (rank[i] == (n_cnt >> 1));
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals;
      sel_ff  <= sel_in;
   end

   assign vals_out = vals_ff;
   assign sel_out  = sel_ff;
endmodule

// ===== sv/rgb_median_filter_3x3_unit.sv =====
// Path: a window's last transfer (image_width+1 beats after the filtered pixel) passes
//   stage 1 (row RAM), stage 2 (window), stage 3 (lanes) and an output FIFO of 8 that
//   decouples back-pressure. Throughput: one beat per cycle while req_tready is high;
//   the row RAM (one read and one write port) and the 3-lane rank stage keep pace.
// Reset: synchronous, active high; counters, window and FIFO clear, size registers
//   return to MAX_WIDTH/MAX_HEIGHT capped at 1024. Row RAM needs no clearing.
module rgb_median_filter_3x3_unit
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [23:0]     req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic            req_tuser,   // is_pixel
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic            rsp_tlast,   // end_of_frame
   input  logic            csr_wr_en,
   input  logic [0:0]      csr_index,
   input  logic [SZ_W-1:0] csr_wdata
);
   localparam int AW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
   localparam logic [SZ_W-1:0] W_RST = SZ_W'(MAX_WIDTH > 1024 ? 1024 : MAX_WIDTH);
   localparam logic [SZ_W-1:0] H_RST = SZ_W'(MAX_HEIGHT > 1024 ? 1024 : MAX_HEIGHT);

   // ---------------- size registers and position counters (stage 0)
   logic [SZ_W-1:0] width_ff, height_ff, col_ff, row_ff;
   logic [SZ_W-1:0] col_in, row_in, cfg_v, c, c1;
   logic signed [SZ_W+1:0] ws, hs, rs, cs, base, crow, ccol, colp, rowp;
   logic [2:0]       col_ok, row_ok;
   logic [WIN_N-1:0] mask0;
   logic [PIX_W-1:0] pix0;
   logic in_frame, ignore, first, emit0, eof0, take, acc;

   always_comb begin
      cfg_v = (csr_wdata == '0) ? SZ_W'(1) : csr_wdata;
      c        = (col_ff >= width_ff) ? '0 : col_ff;
      in_frame = row_ff < height_ff;
      ignore   = in_frame && !req_tuser;
      pix0     = in_frame ? {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]} : '0;
      first    = (c == '0);
      ws = $signed({2'b00, width_ff});
      hs = $signed({2'b00, height_ff});
      rs = $signed({2'b00, row_ff});
      cs = $signed({2'b00, c});
      // first column of a row closes the window of the last pixel two rows up
      base = first ? ws - 13'sd3 : cs - 13'sd2;
      crow = first ? rs - 13'sd2 : rs - 13'sd1;
      ccol = first ? ws - 13'sd1 : cs - 13'sd1;
      for (int s = 0; s < 3; s++) begin
         colp = base + 13'(s);
         col_ok[s] = colp >= 0 && colp < ws && colp >= ccol - 13'sd1 && colp <= ccol + 13'sd1;
      end
      for (int y = 0; y < 3; y++) begin
         rowp = crow - 13'sd1 + 13'(y);
         row_ok[y] = rowp >= 0 && rowp < hs;
      end
      for (int s = 0; s < 3; s++) begin
         for (int y = 0; y < 3; y++) begin
            mask0[s*3+y] = col_ok[s] && row_ok[y];
         end
      end
      emit0 = crow >= 0 && crow < hs;
      eof0  = emit0 && crow == hs - 13'sd1 && ccol == ws - 13'sd1;
      acc   = req_tvalid && req_tready;
      take  = acc && !ignore;
      c1    = c + SZ_W'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (eof0) begin
            col_in = '0;
            row_in = '0;
         end else if (c1 >= width_ff) begin
            col_in = '0;
            row_in = row_ff + SZ_W'(1);
         end else begin
            col_in = c1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= W_RST;
         height_ff <= H_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wr_en) begin
         // any size write restarts the frame
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= (int'(cfg_v) > MAX_WIDTH)  ? SZ_W'(MAX_WIDTH)  : cfg_v;
            CSR_IMAGE_HEIGHT: height_ff <= (int'(cfg_v) > MAX_HEIGHT) ? SZ_W'(MAX_HEIGHT) : cfg_v;
            default: ;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- stage 1: row RAM {upper, middle} read-modify-write
   logic            s1_valid_ff, s1_first_ff, s1_emit_ff, s1_eof_ff, byp_ff;
   logic [AW-1:0]   s1_addr_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [WIN_N-1:0] s1_mask_ff;
   logic [2*PIX_W-1:0] rd_data, eff, byp_data_ff, wr_data;

   assign eff     = byp_ff ? byp_data_ff : rd_data;
   assign wr_data = {eff[PIX_W-1:0], s1_pix_ff};   // upper <- middle, middle <- pixel

   rmf_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_rows (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (take),
      .rd_addr (AW'(c)),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= take;
         if (take) begin
            // same column back to back: read raced the write, forward it
            byp_ff <= s1_valid_ff && (s1_addr_ff == AW'(c));
         end
      end
      if (take) begin
         s1_addr_ff  <= AW'(c);
         s1_pix_ff   <= pix0;
         s1_first_ff <= first;
         s1_mask_ff  <= mask0;
         s1_emit_ff  <= emit0;
         s1_eof_ff   <= eof0;
         byp_data_ff <= wr_data;
      end
   end

   // ---------------- window shift, snapshot into stage 2
   pix_win_type win_ff, win_sh, s2_win_ff;
   logic [WIN_N-1:0] s2_mask_ff;
   logic s2_valid_ff, s2_emit_ff, s2_eof_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win_sh[i] = win_ff[i+3];
      end
      win_sh[6] = eff[2*PIX_W-1:PIX_W];
      win_sh[7] = eff[PIX_W-1:0];
      win_sh[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            win_ff <= win_sh;
         end
      end
      if (s1_valid_ff) begin
         s2_win_ff  <= s1_first_ff ? win_ff : win_sh;
         s2_mask_ff <= s1_mask_ff;
         s2_emit_ff <= s1_emit_ff;
         s2_eof_ff  <= s1_eof_ff;
      end
   end

   // ---------------- stage 3: three channel lanes
   chan_win_type lane_in [3];
   chan_win_type lane_v  [3];
   logic [WIN_N-1:0] lane_sel [3];
   logic s3_valid_ff, s3_emit_ff, s3_eof_ff;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      always_comb begin
         for (int i = 0; i < WIN_N; i++) begin
            lane_in[k][i] = s2_win_ff[i][k*CH_W +: CH_W];
         end
      end
      rmf_lane u_lane (
         .clock    (clock),
         .vals     (lane_in[k]),
         .mask     (s2_mask_ff),
         .vals_out (lane_v[k]),
         .sel_out  (lane_sel[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_emit_ff <= s2_emit_ff;
      s3_eof_ff  <= s2_eof_ff;
   end

   // ---------------- merge: pick flagged element per lane, push to FIFO
   logic [CH_W-1:0] med [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         med[k] = '0;
         for (int i = 0; i < WIN_N; i++) begin
            med[k] = med[k] | (lane_sel[k][i] ? lane_v[k][i] : '0);
         end
      end
   end

   logic [PIX_W:0]   fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wp_ff, rp_ff;
   logic [FIFO_CW-1:0] fill_ff, credit_ff;
   logic push, pop;

   assign push = s3_valid_ff && s3_emit_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + FIFO_AW'(1);
         end
         fill_ff   <= fill_ff + FIFO_CW'(push) - FIFO_CW'(pop);
         // results in flight plus results held: never overruns the FIFO
         credit_ff <= credit_ff + FIFO_CW'(take && emit0) - FIFO_CW'(pop);
      end
      if (push) begin
         // lane 0 is blue, lane 2 is red: red lands in the low byte
         fifo_ff[wp_ff] <= {s3_eof_ff, med[0], med[1], med[2]};
      end
   end

   assign req_tready = credit_ff < FIFO_CW'(FIFO_DEPTH);
   assign rsp_tvalid = fill_ff != '0;
   assign rsp_tlast  = fifo_ff[rp_ff][PIX_W];
   assign rsp_tdata  = fifo_ff[rp_ff][PIX_W-1:0];
endmodule

// ===== sv/rmf_checker.sv =====
module rmf_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_tready,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [23:0]     rsp_tdata,
   input logic            rsp_tlast
);
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result visible after reset");
   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");
endmodule

bind rgb_median_filter_3x3_unit rmf_checker u_rmf_checker (.*);
